// ----- rtl/grwd_pkg.sv -----
package grwd_pkg;

  localparam int unsigned GRID_SIZE  = 16;
  localparam int unsigned CELL_SHIFT = 14;
  localparam int unsigned POS_W      = 18;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned RATIO_W    = 31;
  localparam int unsigned NA_W       = 21;
  localparam int unsigned NB_W       = 40;
  localparam int unsigned D2_W       = 40;
  localparam int unsigned DIST_W     = 19;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = 19'h7FFFF;

  localparam logic [31:0] SIN_A = 32'd25719;
  localparam logic [31:0] SIN_B = 32'd10477;
  localparam logic [31:0] SIN_C = 32'd1142;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_4  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_8  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_12 = 3'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_FAM,
    ST_DIV,
    ST_INIT,
    ST_NB,
    ST_WALK,
    ST_SQA,
    ST_SQB,
    ST_SUM,
    ST_PICK,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [RATIO_W-1:0] num;
    logic [MAG_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/grwd_div.sv -----
module grwd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grwd_pkg::div_req_t req_i,
  output grwd_pkg::div_rsp_t rsp_o
);

  logic [grwd_pkg::RATIO_W-1:0] quo_q;
  logic [grwd_pkg::MAG_W-1:0]   rem_q, den_q, rem_d;
  logic [4:0]                   cnt_q;
  logic                         busy_q, done_q;
  logic [grwd_pkg::MAG_W:0]     trial;
  logic                         ge;

  assign trial = {rem_q, quo_q[grwd_pkg::RATIO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? grwd_pkg::MAG_W'(trial - {1'b0, den_q})
                    : grwd_pkg::MAG_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(grwd_pkg::RATIO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[grwd_pkg::RATIO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- rtl/grid_ray_wall_distance_unit.sv -----
// Casts one ray over a 16 by 16 occupancy map of 16384-unit cells and returns the distance to the
// first wall, the side that was hit and a hit flag. Per word it computes sine and cosine on the
// shared multiplier, then per line family waits on the divider for the slope, walks up to 17 cell
// steps and, on a hit, squares the distance on the multiplier; then it takes the square root, loads
// the output register and returns to idle. The input is stalled from acceptance until the result
// is loaded into the output register.
module grid_ray_wall_distance_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [grwd_pkg::POS_W-1:0]      ray_x_i,
  input  logic [grwd_pkg::POS_W-1:0]      ray_y_i,
  input  logic [11:0]                     ray_angle_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [grwd_pkg::DIST_W-1:0]     wall_distance_o,
  output logic                            wall_found_o,
  output logic                            hit_side_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [grwd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);

  grwd_pkg::state_e state_q, state_d;

  logic [63:0] map_q [4];

  logic [grwd_pkg::POS_W-1:0]   px_q, py_q;
  logic [11:0]                  ang_q;
  logic                         pass_q, pass_d, fam_q, fam_d;
  logic [63:0]                  p_q, p_d;
  logic [grwd_pkg::MAG_W-1:0]   x2_q, x2_d, sin_mag_q, sin_mag_d, cos_mag_q, cos_mag_d;
  logic [grwd_pkg::RATIO_W-1:0] ratio_q, ratio_d;
  logic [grwd_pkg::NA_W-1:0]    na_q, na_d;
  logic [grwd_pkg::NB_W-1:0]    nb_q, nb_d;
  logic [29:0]                  stepb_q, stepb_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic                         hv_q, hv_d, hh_q, hh_d;
  logic [grwd_pkg::D2_W-1:0]    dv_q, dv_d, dh_q, dh_d, e_q, e_d;
  logic [grwd_pkg::D2_W-1:0]    v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic                         found_q, found_d, side_q, side_d;
  logic                         out_valid_q, out_valid_d;
  logic [grwd_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic                         ofound_q, ofound_d, oside_q, oside_d;

  logic [1:0]  q_s, q_c;
  logic [13:0] u;
  logic [14:0] sin_x, cos_x, x_sel;
  logic        sin_neg, cos_neg;
  logic [31:0] mul_a, mul_b, inner, outer;

  logic [grwd_pkg::MAG_W-1:0]   num_mag, den_mag;
  logic [grwd_pkg::POS_W-1:0]   pa, pb;
  logic                         sa_neg, sb_neg, sb_zero;
  logic [3:0]                   base, ca, cb, row, col;
  logic [4:0]                   base_p1;
  logic [grwd_pkg::NA_W-1:0]    na_init, da_full, ea_full;
  logic [63:0]                  db_sum;
  logic [30:0]                  db;
  logic [grwd_pkg::NB_W-1:0]    eb_full;
  logic [31:0]                  stepb_sum;
  logic                         in_grid, occ, fam_end, emit_ok;
  logic                         horiz;
  logic [grwd_pkg::D2_W-1:0]    root_sum;
  logic                         root_ge;

  grwd_pkg::div_req_t div_req;
  grwd_pkg::div_rsp_t div_rsp;

  grwd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q_s     = ang_q[11:10];
  assign q_c     = q_s + 2'd1;
  assign u       = {ang_q[9:0], 4'd0};
  assign sin_x   = q_s[0] ? 15'd16384 - {1'b0, u} : {1'b0, u};
  assign cos_x   = q_c[0] ? 15'd16384 - {1'b0, u} : {1'b0, u};
  assign x_sel   = pass_q ? cos_x : sin_x;
  assign sin_neg = q_s[1];
  assign cos_neg = q_c[1];

  assign inner = grwd_pkg::SIN_B - {18'd0, p_q[27:14]};
  assign outer = grwd_pkg::SIN_A - {18'd0, p_q[27:14]};

  assign num_mag = fam_q ? cos_mag_q : sin_mag_q;
  assign den_mag = fam_q ? sin_mag_q : cos_mag_q;
  assign pa      = fam_q ? py_q : px_q;
  assign pb      = fam_q ? px_q : py_q;
  assign sa_neg  = fam_q ? sin_neg : cos_neg;
  assign sb_neg  = fam_q ? cos_neg : sin_neg;
  assign sb_zero = (num_mag == '0);

  assign base    = pa[17:14];
  assign base_p1 = {1'b0, base} + 5'd1;
  assign na_init = sa_neg ? {3'd0, base, 14'd0} - 21'd1 : {2'd0, base_p1, 14'd1};
  assign da_full = sa_neg ? {3'd0, pa} - na_init : na_init - {3'd0, pa};

  assign db_sum    = p_q + 64'd32768;
  assign db        = db_sum[46:16];
  assign stepb_sum = {1'b0, ratio_q} + 32'd2;

  assign in_grid = (na_q[20:18] == 3'd0) && (nb_q[39:18] == '0);
  assign ca      = na_q[17:14];
  assign cb      = nb_q[17:14];
  assign row     = fam_q ? ca : cb;
  assign col     = fam_q ? cb : ca;
  assign occ     = map_q[row[3:2]][{row[1:0], col}];
  assign ea_full = (na_q >= {3'd0, pa}) ? na_q - {3'd0, pa} : {3'd0, pa} - na_q;
  assign eb_full = (nb_q >= {22'd0, pb}) ? nb_q - {22'd0, pb} : {22'd0, pb} - nb_q;

  assign fam_end = ((state_q == grwd_pkg::ST_FAM) && (den_mag == '0))
                || ((state_q == grwd_pkg::ST_WALK)
                    && (!in_grid || (!occ && cnt_q == 5'(grwd_pkg::GRID_SIZE))))
                || (state_q == grwd_pkg::ST_SUM);

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign horiz    = hh_q && (!hv_q || (dh_q < dv_q));
  assign root_sum = res_q + bit_q;
  assign root_ge  = v_q >= root_sum;

  assign div_req.start = (state_q == grwd_pkg::ST_FAM) && (den_mag != '0);
  assign div_req.num   = {num_mag, 16'd0} + {17'd0, den_mag[14:1]};
  assign div_req.den   = den_mag;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grwd_pkg::ST_IDLE: if (in_valid_i) state_d = grwd_pkg::ST_SQ;
      grwd_pkg::ST_SQ:   state_d = grwd_pkg::ST_M1;
      grwd_pkg::ST_M1:   state_d = grwd_pkg::ST_M2;
      grwd_pkg::ST_M2:   state_d = grwd_pkg::ST_M3;
      grwd_pkg::ST_M3:   state_d = grwd_pkg::ST_M4;
      grwd_pkg::ST_M4:   state_d = pass_q ? grwd_pkg::ST_FAM : grwd_pkg::ST_SQ;
      grwd_pkg::ST_FAM: begin
        if (fam_end) state_d = fam_q ? grwd_pkg::ST_PICK : grwd_pkg::ST_FAM;
        else state_d = grwd_pkg::ST_DIV;
      end
      grwd_pkg::ST_DIV:  if (div_rsp.done) state_d = grwd_pkg::ST_INIT;
      grwd_pkg::ST_INIT: state_d = grwd_pkg::ST_NB;
      grwd_pkg::ST_NB:   state_d = grwd_pkg::ST_WALK;
      grwd_pkg::ST_WALK: begin
        if (fam_end) state_d = fam_q ? grwd_pkg::ST_PICK : grwd_pkg::ST_FAM;
        else if (occ) state_d = grwd_pkg::ST_SQA;
      end
      grwd_pkg::ST_SQA:  state_d = grwd_pkg::ST_SQB;
      grwd_pkg::ST_SQB:  state_d = grwd_pkg::ST_SUM;
      grwd_pkg::ST_SUM:  state_d = fam_q ? grwd_pkg::ST_PICK : grwd_pkg::ST_FAM;
      grwd_pkg::ST_PICK: state_d = grwd_pkg::ST_ROOT;
      grwd_pkg::ST_ROOT: if (bit_q == '0) state_d = grwd_pkg::ST_EMIT;
      grwd_pkg::ST_EMIT: if (emit_ok) state_d = grwd_pkg::ST_IDLE;
      default:           state_d = grwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    pass_d      = pass_q;
    fam_d       = fam_q;
    x2_d        = x2_q;
    sin_mag_d   = sin_mag_q;
    cos_mag_d   = cos_mag_q;
    ratio_d     = ratio_q;
    na_d        = na_q;
    nb_d        = nb_q;
    stepb_d     = stepb_q;
    cnt_d       = cnt_q;
    hv_d        = hv_q;
    hh_d        = hh_q;
    dv_d        = dv_q;
    dh_d        = dh_q;
    e_d         = e_q;
    v_d         = v_q;
    res_d       = res_q;
    bit_d       = bit_q;
    found_d     = found_q;
    side_d      = side_q;
    dist_d      = dist_q;
    ofound_d    = ofound_q;
    oside_d     = oside_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      grwd_pkg::ST_IDLE: begin
        pass_d = 1'b0;
        fam_d  = 1'b0;
        hv_d   = 1'b0;
        hh_d   = 1'b0;
      end
      grwd_pkg::ST_SQ: begin
        mul_a = {17'd0, x_sel};
        mul_b = {17'd0, x_sel};
      end
      grwd_pkg::ST_M1: begin
        x2_d  = p_q[28:14];
        mul_a = {17'd0, p_q[28:14]};
        mul_b = grwd_pkg::SIN_C;
      end
      grwd_pkg::ST_M2: begin
        mul_a = {17'd0, x2_q};
        mul_b = inner;
      end
      grwd_pkg::ST_M3: begin
        mul_a = {17'd0, x_sel};
        mul_b = outer;
      end
      grwd_pkg::ST_M4: begin
        if (pass_q) cos_mag_d = p_q[28:14];
        else sin_mag_d = p_q[28:14];
        pass_d = 1'b1;
      end
      grwd_pkg::ST_DIV: ratio_d = div_rsp.quo;
      grwd_pkg::ST_INIT: begin
        na_d  = na_init;
        cnt_d = '0;
        mul_a = {17'd0, da_full[14:0]};
        mul_b = {1'b0, ratio_q};
      end
      grwd_pkg::ST_NB: begin
        stepb_d = stepb_sum[31:2];
        if (sb_zero) nb_d = {22'd0, pb};
        else if (sb_neg) nb_d = {22'd0, pb} - {9'd0, db};
        else nb_d = {22'd0, pb} + {9'd0, db};
      end
      grwd_pkg::ST_WALK: begin
        na_d  = sa_neg ? na_q - 21'(1 << grwd_pkg::CELL_SHIFT)
                       : na_q + 21'(1 << grwd_pkg::CELL_SHIFT);
        if (!sb_zero) begin
          nb_d = sb_neg ? nb_q - {10'd0, stepb_q} : nb_q + {10'd0, stepb_q};
        end
        cnt_d = cnt_q + 5'd1;
        if (in_grid && occ) begin
          na_d = na_q;
          nb_d = nb_q;
        end
      end
      grwd_pkg::ST_SQA: begin
        mul_a = {12'd0, ea_full[19:0]};
        mul_b = {12'd0, ea_full[19:0]};
      end
      grwd_pkg::ST_SQB: begin
        e_d   = p_q[grwd_pkg::D2_W-1:0];
        mul_a = {12'd0, eb_full[19:0]};
        mul_b = {12'd0, eb_full[19:0]};
      end
      grwd_pkg::ST_SUM: begin
        if (fam_q) begin
          hh_d = 1'b1;
          dh_d = e_q + p_q[grwd_pkg::D2_W-1:0];
        end else begin
          hv_d = 1'b1;
          dv_d = e_q + p_q[grwd_pkg::D2_W-1:0];
        end
      end
      grwd_pkg::ST_PICK: begin
        found_d = hv_q || hh_q;
        side_d  = horiz;
        v_d     = horiz ? dh_q : (hv_q ? dv_q : '0);
        res_d   = '0;
        bit_d   = grwd_pkg::D2_W'(1) << 38;
      end
      grwd_pkg::ST_ROOT: begin
        if (bit_q != '0) begin
          if (root_ge) begin
            v_d   = v_q - root_sum;
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      grwd_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          ofound_d    = found_q;
          oside_d     = found_q && side_q;
          if (!found_q || res_q > {21'd0, grwd_pkg::DIST_MAX}) dist_d = grwd_pkg::DIST_MAX;
          else dist_d = res_q[grwd_pkg::DIST_W-1:0];
        end
      end
      default: ;
    endcase

    if (fam_end) fam_d = 1'b1;
    p_d = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grwd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        map_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          grwd_pkg::CFG_ROWS_0:  map_q[0] <= cfg_data_i;
          grwd_pkg::CFG_ROWS_4:  map_q[1] <= cfg_data_i;
          grwd_pkg::CFG_ROWS_8:  map_q[2] <= cfg_data_i;
          grwd_pkg::CFG_ROWS_12: map_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == grwd_pkg::ST_IDLE && in_valid_i) begin
      px_q  <= ray_x_i;
      py_q  <= ray_y_i;
      ang_q <= ray_angle_i;
    end
    pass_q    <= pass_d;
    fam_q     <= fam_d;
    p_q       <= p_d;
    x2_q      <= x2_d;
    sin_mag_q <= sin_mag_d;
    cos_mag_q <= cos_mag_d;
    ratio_q   <= ratio_d;
    na_q      <= na_d;
    nb_q      <= nb_d;
    stepb_q   <= stepb_d;
    cnt_q     <= cnt_d;
    hv_q      <= hv_d;
    hh_q      <= hh_d;
    dv_q      <= dv_d;
    dh_q      <= dh_d;
    e_q       <= e_d;
    v_q       <= v_d;
    res_q     <= res_d;
    bit_q     <= bit_d;
    found_q   <= found_d;
    side_q    <= side_d;
    dist_q    <= dist_d;
    ofound_q  <= ofound_d;
    oside_q   <= oside_d;
  end

  assign in_stall_o      = (state_q != grwd_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign wall_distance_o = dist_q;
  assign wall_found_o    = ofound_q;
  assign hit_side_o      = oside_q;

endmodule
